### hdl/crv_pkg.sv
package crv_pkg;

    localparam int HEADER_BYTES = 36;
    localparam int HDR_CRC_SPAN = 32;
    localparam int HIDX_W       = $clog2(HEADER_BYTES);

    localparam logic [31:0] CRC_POLY = 32'hedb8_8320;
    localparam logic [31:0] CRC_ONES = 32'hffff_ffff;

    localparam logic [7:0] REG_MAGIC          = 8'd0;
    localparam logic [7:0] REG_FMT_MAJOR      = 8'd1;
    localparam logic [7:0] REG_FMT_MINOR_MAX  = 8'd2;
    localparam logic [7:0] REG_MAX_LEN        = 8'd3;
    localparam logic [7:0] REG_ANY_TYPE       = 8'd4;
    localparam logic [7:0] REG_EXP_TYPE       = 8'd5;
    localparam logic [7:0] REG_LAYOUT_MAJOR   = 8'd6;
    localparam logic [7:0] REG_LAYOUT_MIN_MAX = 8'd7;

    typedef enum logic [1:0] {
        KIND_HDR_CRC,
        KIND_HDR_CRC_END,
        KIND_HDR_TAIL,
        KIND_PAYLOAD
    } kind_t;

    typedef enum logic [3:0] {
        ST_OK        = 4'd0,
        ST_TRUNCATED = 4'd1,
        ST_MAGIC     = 4'd2,
        ST_FORMAT    = 4'd3,
        ST_MALFORMED = 4'd4,
        ST_HDR_CRC   = 4'd5,
        ST_BOUNDS    = 4'd6,
        ST_TRAILING  = 4'd7,
        ST_PAY_CRC   = 4'd8,
        ST_TYPE      = 4'd9,
        ST_SCHEMA    = 4'd10
    } status_t;

    typedef struct packed {
        logic [7:0]        data;
        logic              last;
        kind_t             kind;
        logic [HIDX_W-1:0] hidx;
        logic [31:0]       count;
    } item_t;

    typedef struct packed {
        logic [31:0] magic;
        logic [7:0]  fmt_major;
        logic [7:0]  fmt_minor_max;
        logic [31:0] max_len;
        logic [15:0] any_type;
        logic [15:0] exp_type;
        logic [15:0] layout_major;
        logic [15:0] layout_minor_max;
    } cfg_t;

    typedef struct packed {
        logic [31:0] body_len;
        logic [63:0] generation;
        logic [15:0] layout_minor;
        logic [15:0] layout_major;
        logic [15:0] rec_kind;
        status_t     status;
    } res_t;

    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++)
        begin
            c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
        end
        return c;
    endfunction

endpackage

### hdl/crv_front.sv
module crv_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        in_data,
    input  logic              in_last,
    output logic              push_valid,
    input  logic              push_ready,
    output crv_pkg::item_t    push_item
);

    logic [31:0] count_reg;
    logic [31:0] count_next;
    logic [31:0] count_after;
    logic        accept;

    assign in_ready    = push_ready;
    assign push_valid  = in_valid;
    assign accept      = in_valid && push_ready;
    assign count_after = (count_reg == 32'hffff_ffff) ? count_reg : count_reg + 32'd1;

    always_comb
    begin
        push_item.data  = in_data;
        push_item.last  = in_last;
        push_item.hidx  = count_reg[crv_pkg::HIDX_W-1:0];
        push_item.count = count_after;
        if (count_reg < 32'(crv_pkg::HDR_CRC_SPAN - 1))
            push_item.kind = crv_pkg::KIND_HDR_CRC;
        else if (count_reg == 32'(crv_pkg::HDR_CRC_SPAN - 1))
            push_item.kind = crv_pkg::KIND_HDR_CRC_END;
        else if (count_reg < 32'(crv_pkg::HEADER_BYTES))
            push_item.kind = crv_pkg::KIND_HDR_TAIL;
        else
            push_item.kind = crv_pkg::KIND_PAYLOAD;
    end

    always_comb
    begin
        count_next = count_reg;
        if (accept)
            count_next = in_last ? 32'd0 : count_after;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= 32'd0;
        else
            count_reg <= count_next;
    end

    // a closing beat restarts the record count
    a_restart : assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_last) |=> (count_reg == 32'd0))
        else $error("byte count not cleared after closing beat");

endmodule

### hdl/crv_queue.sv
module crv_queue
#(
    parameter int DEPTH = 2
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_valid,
    output logic              push_ready,
    input  crv_pkg::item_t    push_item,
    output logic              pop_valid,
    input  logic              pop,
    output crv_pkg::item_t    pop_item
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    crv_pkg::item_t mem_reg [DEPTH];
    logic [PW-1:0]  wr_ptr_reg;
    logic [PW-1:0]  wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg;
    logic [PW-1:0]  rd_ptr_next;
    logic [CW-1:0]  fill_reg;
    logic [CW-1:0]  fill_next;
    logic           do_push;
    logic           do_pop;

    assign push_ready = (fill_reg != CW'(DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign pop_item   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        if (do_push && !do_pop)
            fill_next = fill_reg + CW'(1);
        else if (do_pop && !do_push)
            fill_next = fill_reg - CW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    a_fill : assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CW'(DEPTH))
        else $error("queue fill beyond depth");

endmodule

### hdl/crv_back.sv
module crv_back
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    input  crv_pkg::item_t    q_item,
    output logic              q_pop,
    input  crv_pkg::cfg_t     cfg,
    output logic              out_valid,
    input  logic              out_ready,
    output crv_pkg::res_t     out_res
);

    logic [7:0]  hdr_reg [crv_pkg::HEADER_BYTES];

    logic [31:0] crc_reg;
    logic [31:0] hcrc_reg;
    logic [31:0] crc_step;
    logic [31:0] crc_new;
    logic [31:0] hcrc_new;

    logic        pend_valid_reg;
    logic [31:0] pend_count_reg;
    logic [31:0] pend_crc_reg;
    logic [31:0] pend_hcrc_reg;

    logic          out_valid_reg;
    crv_pkg::res_t out_res_reg;
    crv_pkg::res_t res_next;

    logic        eval_move;
    logic        back_go;

    logic [31:0] f_magic;
    logic [15:0] f_hsize;
    logic [15:0] f_rtype;
    logic [15:0] f_smaj;
    logic [15:0] f_smin;
    logic [15:0] f_resv;
    logic [31:0] f_plen;
    logic [63:0] f_gen;
    logic [31:0] f_pcrc;
    logic [31:0] f_hcrc;
    logic [31:0] avail;
    crv_pkg::status_t status;

    assign eval_move = pend_valid_reg && (!out_valid_reg || out_ready);
    assign back_go   = q_valid && (!pend_valid_reg || eval_move);
    assign q_pop     = back_go;
    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

    // byte-wide CRC step, unrolled
    assign crc_step = crv_pkg::crc_byte(crc_reg, q_item.data);

    always_comb
    begin
        crc_new  = crc_reg;
        hcrc_new = hcrc_reg;
        case (q_item.kind)
            crv_pkg::KIND_HDR_CRC:
                crc_new = crc_step;
            crv_pkg::KIND_HDR_CRC_END:
            begin
                hcrc_new = crc_step ^ crv_pkg::CRC_ONES;
                crc_new  = crv_pkg::CRC_ONES;
            end
            crv_pkg::KIND_PAYLOAD:
                crc_new = crc_step;
            default:
                crc_new = crc_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (back_go && q_item.kind != crv_pkg::KIND_PAYLOAD)
            hdr_reg[q_item.hidx] <= q_item.data;
        if (back_go && q_item.last)
        begin
            pend_count_reg <= q_item.count;
            pend_crc_reg   <= crc_new;
            pend_hcrc_reg  <= hcrc_new;
        end
        if (eval_move)
            out_res_reg <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg        <= crv_pkg::CRC_ONES;
            hcrc_reg       <= 32'd0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (back_go)
            begin
                if (q_item.last)
                begin
                    crc_reg  <= crv_pkg::CRC_ONES;
                    hcrc_reg <= 32'd0;
                end
                else
                begin
                    crc_reg  <= crc_new;
                    hcrc_reg <= hcrc_new;
                end
            end
            if (back_go && q_item.last)
                pend_valid_reg <= 1'b1;
            else if (eval_move)
                pend_valid_reg <= 1'b0;
            if (eval_move)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // header fields, little endian
    assign f_magic = {hdr_reg[3], hdr_reg[2], hdr_reg[1], hdr_reg[0]};
    assign f_hsize = {hdr_reg[7], hdr_reg[6]};
    assign f_rtype = {hdr_reg[9], hdr_reg[8]};
    assign f_smaj  = {hdr_reg[11], hdr_reg[10]};
    assign f_smin  = {hdr_reg[13], hdr_reg[12]};
    assign f_resv  = {hdr_reg[15], hdr_reg[14]};
    assign f_plen  = {hdr_reg[19], hdr_reg[18], hdr_reg[17], hdr_reg[16]};
    assign f_gen   = {hdr_reg[27], hdr_reg[26], hdr_reg[25], hdr_reg[24],
                      hdr_reg[23], hdr_reg[22], hdr_reg[21], hdr_reg[20]};
    assign f_pcrc  = {hdr_reg[31], hdr_reg[30], hdr_reg[29], hdr_reg[28]};
    assign f_hcrc  = {hdr_reg[35], hdr_reg[34], hdr_reg[33], hdr_reg[32]};
    assign avail   = pend_count_reg - 32'(crv_pkg::HEADER_BYTES);

    always_comb
    begin
        if (pend_count_reg < 32'(crv_pkg::HEADER_BYTES))
            status = crv_pkg::ST_TRUNCATED;
        else if (f_magic != cfg.magic)
            status = crv_pkg::ST_MAGIC;
        else if (hdr_reg[4] != cfg.fmt_major || hdr_reg[5] > cfg.fmt_minor_max)
            status = crv_pkg::ST_FORMAT;
        else if (f_hsize != 16'(crv_pkg::HEADER_BYTES))
            status = crv_pkg::ST_MALFORMED;
        else if (pend_hcrc_reg != f_hcrc)
            status = crv_pkg::ST_HDR_CRC;
        else if (f_resv != 16'd0)
            status = crv_pkg::ST_MALFORMED;
        else if (f_rtype == cfg.any_type || f_smaj == 16'd0)
            status = crv_pkg::ST_MALFORMED;
        else if (f_plen > cfg.max_len)
            status = crv_pkg::ST_BOUNDS;
        else if (pend_count_reg == 32'hffff_ffff)
            status = crv_pkg::ST_TRAILING;
        else if (f_plen > avail)
            status = crv_pkg::ST_TRUNCATED;
        else if (f_plen < avail)
            status = crv_pkg::ST_TRAILING;
        else if ((pend_crc_reg ^ crv_pkg::CRC_ONES) != f_pcrc)
            status = crv_pkg::ST_PAY_CRC;
        else if (cfg.exp_type != cfg.any_type && f_rtype != cfg.exp_type)
            status = crv_pkg::ST_TYPE;
        else if (cfg.layout_major != 16'd0 &&
                 (f_smaj != cfg.layout_major || f_smin > cfg.layout_minor_max))
            status = crv_pkg::ST_SCHEMA;
        else
            status = crv_pkg::ST_OK;
    end

    always_comb
    begin
        res_next = '0;
        res_next.status = status;
        if (status == crv_pkg::ST_OK)
        begin
            res_next.rec_kind     = f_rtype;
            res_next.layout_major = f_smaj;
            res_next.layout_minor = f_smin;
            res_next.generation   = f_gen;
            res_next.body_len     = f_plen;
        end
    end

    a_keep_pend : assert property (@(posedge clk) disable iff (!rst_n)
        (pend_valid_reg && out_valid_reg && !out_ready) |=> pend_valid_reg)
        else $error("pending result lost under back-pressure");

    a_zero_fail : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_res_reg.status != crv_pkg::ST_OK) |->
        (out_res_reg.rec_kind == 16'd0 && out_res_reg.generation == 64'd0 &&
         out_res_reg.body_len == 32'd0))
        else $error("failed record carries decoded fields");

endmodule

### hdl/crc32_record_validator_top.sv
// Channel | Dir | Beat content
// s_*     | in  | tdata[7:0] record byte, tlast closes the record
// m_*     | out | one result per record: status, kind, layout version, generation, length
// cfg_*   | in  | register index and 32-bit write data
//
// One byte per cycle while the output is not stalled; the CRC unit folds a whole byte each cycle.
// The closing beat passes the byte queue and the pending record registers, then the result reaches the output register.
// Reset clears the configuration to defaults and the CRC and byte count state.
// An output stall holds one result and one more pending; the byte queue
// then fills and s_tready drops. cfg_ready is always high.
module crc32_record_validator_top
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [7:0]    s_tdata,   // [7:0] data_byte
    input  logic          s_tlast,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [151:0]  m_tdata,   // status, rec_kind, layout_major,
                                     // layout_minor, generation, body_len
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [7:0]    cfg_index,
    input  logic [31:0]   cfg_data
);

    crv_pkg::cfg_t  cfg_reg;
    crv_pkg::item_t push_item;
    crv_pkg::item_t pop_item;
    crv_pkg::res_t  res;
    logic           push_valid;
    logic           push_ready;
    logic           pop_valid;
    logic           pop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.magic            <= 32'd0;
            cfg_reg.fmt_major        <= 8'd1;
            cfg_reg.fmt_minor_max    <= 8'd0;
            cfg_reg.max_len          <= 32'd4096;
            cfg_reg.any_type         <= 16'd0;
            cfg_reg.exp_type         <= 16'd0;
            cfg_reg.layout_major     <= 16'd0;
            cfg_reg.layout_minor_max <= 16'hffff;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                crv_pkg::REG_MAGIC:          cfg_reg.magic            <= cfg_data;
                crv_pkg::REG_FMT_MAJOR:      cfg_reg.fmt_major        <= cfg_data[7:0];
                crv_pkg::REG_FMT_MINOR_MAX:  cfg_reg.fmt_minor_max    <= cfg_data[7:0];
                crv_pkg::REG_MAX_LEN:        cfg_reg.max_len          <= cfg_data;
                crv_pkg::REG_ANY_TYPE:       cfg_reg.any_type         <= cfg_data[15:0];
                crv_pkg::REG_EXP_TYPE:       cfg_reg.exp_type         <= cfg_data[15:0];
                crv_pkg::REG_LAYOUT_MAJOR:   cfg_reg.layout_major     <= cfg_data[15:0];
                crv_pkg::REG_LAYOUT_MIN_MAX: cfg_reg.layout_minor_max <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    crv_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_data    (s_tdata),
        .in_last    (s_tlast),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    crv_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop        (pop),
        .pop_item   (pop_item)
    );

    crv_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (pop_valid),
        .q_item    (pop_item),
        .q_pop     (pop),
        .cfg       (cfg_reg),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (res)
    );

    assign m_tdata = {4'd0, res.body_len, res.generation, res.layout_minor,
                      res.layout_major, res.rec_kind, 4'(res.status)};

endmodule

### dv/crc32_record_validator_top_test.sv
`timescale 1ns / 100ps

class verdict_tracker;
    logic [31:0] magic;
    logic [7:0]  fmt_major;
    logic [7:0]  fmt_minor_max;
    logic [31:0] max_len;
    logic [15:0] any_type;
    logic [15:0] exp_type;
    logic [15:0] layout_major;
    logic [15:0] layout_minor_max;

    logic [31:0] nbytes;
    logic [31:0] crc_acc;
    logic [31:0] hdr_crc;
    logic [7:0]  hdr [crv_pkg::HEADER_BYTES];

    crv_pkg::res_t pending_verdicts[$];
    int   mismatches;
    int   checked;
    int   clean;
    int   seen [11];

    function new();
        magic            = 32'd0;
        fmt_major        = 8'd1;
        fmt_minor_max    = 8'd0;
        max_len          = 32'd4096;
        any_type         = 16'd0;
        exp_type         = 16'd0;
        layout_major     = 16'd0;
        layout_minor_max = 16'hffff;
        foreach (hdr[i])
            hdr[i] = 8'd0;
        foreach (seen[i])
            seen[i] = 0;
        mismatches = 0;
        checked    = 0;
        clean      = 0;
        clear_record();
    endfunction

    function void clear_record();
        nbytes  = 32'd0;
        crc_acc = 32'hffff_ffff;
        hdr_crc = 32'd0;
    endfunction

    function void write_reg(logic [7:0] idx, logic [31:0] d);
        case (idx)
            crv_pkg::REG_MAGIC:          magic            = d;
            crv_pkg::REG_FMT_MAJOR:      fmt_major        = d[7:0];
            crv_pkg::REG_FMT_MINOR_MAX:  fmt_minor_max    = d[7:0];
            crv_pkg::REG_MAX_LEN:        max_len          = d;
            crv_pkg::REG_ANY_TYPE:       any_type         = d[15:0];
            crv_pkg::REG_EXP_TYPE:       exp_type         = d[15:0];
            crv_pkg::REG_LAYOUT_MAJOR:   layout_major     = d[15:0];
            crv_pkg::REG_LAYOUT_MIN_MAX: layout_minor_max = d[15:0];
            default: ;
        endcase
    endfunction

    function logic [31:0] crc_step(logic [31:0] crc, logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
                c = (c >> 1) ^ crv_pkg::CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

    function logic [15:0] le16(int off);
        return {hdr[off + 1], hdr[off]};
    endfunction

    function logic [31:0] le32(int off);
        return {le16(off + 2), le16(off)};
    endfunction

    function crv_pkg::res_t judge_record();
        crv_pkg::res_t    r;
        crv_pkg::status_t st;
        logic [15:0] rtype;
        logic [15:0] smaj;
        logic [15:0] smin;
        logic [31:0] plen;
        logic [31:0] avail;
        r     = '0;
        rtype = le16(8);
        smaj  = le16(10);
        smin  = le16(12);
        plen  = le32(16);
        avail = nbytes - 32'(crv_pkg::HEADER_BYTES);
        if (nbytes < crv_pkg::HEADER_BYTES)
            st = crv_pkg::ST_TRUNCATED;
        else if (le32(0) != magic)
            st = crv_pkg::ST_MAGIC;
        else if (hdr[4] != fmt_major || hdr[5] > fmt_minor_max)
            st = crv_pkg::ST_FORMAT;
        else if (le16(6) != 16'(crv_pkg::HEADER_BYTES))
            st = crv_pkg::ST_MALFORMED;
        else if (hdr_crc != le32(32))
            st = crv_pkg::ST_HDR_CRC;
        else if (le16(14) != 16'd0)
            st = crv_pkg::ST_MALFORMED;
        else if (rtype == any_type || smaj == 16'd0)
            st = crv_pkg::ST_MALFORMED;
        else if (plen > max_len)
            st = crv_pkg::ST_BOUNDS;
        else if (nbytes == 32'hffff_ffff)
            st = crv_pkg::ST_TRAILING;
        else if (plen > avail)
            st = crv_pkg::ST_TRUNCATED;
        else if (plen < avail)
            st = crv_pkg::ST_TRAILING;
        else if (~crc_acc != le32(28))
            st = crv_pkg::ST_PAY_CRC;
        else if (exp_type != any_type && rtype != exp_type)
            st = crv_pkg::ST_TYPE;
        else if (layout_major != 16'd0 &&
                 (smaj != layout_major || smin > layout_minor_max))
            st = crv_pkg::ST_SCHEMA;
        else
            st = crv_pkg::ST_OK;
        r.status = st;
        if (st == crv_pkg::ST_OK)
        begin
            r.rec_kind     = rtype;
            r.layout_major = smaj;
            r.layout_minor = smin;
            r.generation   = {le32(24), le32(20)};
            r.body_len     = plen;
        end
        return r;
    endfunction

    function void note_byte(logic [7:0] d, logic fin);
        if (nbytes < crv_pkg::HEADER_BYTES)
            hdr[nbytes[5:0]] = d;
        if (nbytes < crv_pkg::HDR_CRC_SPAN)
        begin
            crc_acc = crc_step(crc_acc, d);
            if (nbytes == crv_pkg::HDR_CRC_SPAN - 1)
            begin
                hdr_crc = ~crc_acc;
                crc_acc = 32'hffff_ffff;
            end
        end
        else if (nbytes >= crv_pkg::HEADER_BYTES)
            crc_acc = crc_step(crc_acc, d);
        if (nbytes != 32'hffff_ffff)
            nbytes++;
        if (fin)
        begin
            pending_verdicts.push_back(judge_record());
            clear_record();
        end
    endfunction

    function void complain(string what, logic [63:0] want, logic [63:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("MISMATCH %s: expected %h, got %h", what, want, got);
    endfunction

    function void check_verdict(logic [151:0] beat);
        crv_pkg::res_t got;
        crv_pkg::res_t want;
        got = beat[147:0];
        checked++;
        if (pending_verdicts.size() == 0)
        begin
            complain("result with none outstanding", 64'd0, {60'd0, got.status});
            return;
        end
        want = pending_verdicts.pop_front();
        seen[int'(want.status)]++;
        if (want.status == crv_pkg::ST_OK)
            clean++;
        if (got.status !== want.status)
            complain("status", {60'd0, want.status}, {60'd0, got.status});
        if (got.rec_kind !== want.rec_kind)
            complain("rec_kind", 64'(want.rec_kind), 64'(got.rec_kind));
        if (got.layout_major !== want.layout_major)
            complain("layout_major", 64'(want.layout_major), 64'(got.layout_major));
        if (got.layout_minor !== want.layout_minor)
            complain("layout_minor", 64'(want.layout_minor), 64'(got.layout_minor));
        if (got.generation !== want.generation)
            complain("generation", want.generation, got.generation);
        if (got.body_len !== want.body_len)
            complain("body_len", 64'(want.body_len), 64'(got.body_len));
        if (beat[151:148] !== 4'd0)
            complain("tdata pad bits", 64'd0, {60'd0, beat[151:148]});
    endfunction

    function int pending();
        return pending_verdicts.size();
    endfunction
endclass

module crc32_record_validator_top_test;

    localparam int QUIET_LIMIT = 2000;

    typedef enum int {
        F_NONE,
        F_SHORT_HDR,
        F_MAGIC,
        F_FMT_MAJOR,
        F_FMT_MINOR,
        F_HDR_SIZE,
        F_HDR_CRC,
        F_RESERVED,
        F_ANY_TYPE,
        F_SMAJ_ZERO,
        F_BOUNDS,
        F_SHORT_PAY,
        F_TRAILING,
        F_PAY_CRC,
        F_EXP_TYPE,
        F_LAYOUT_MAJOR,
        F_LAYOUT_MINOR,
        F_NOISE
    } fault_e;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [7:0]   s_tdata;
    logic         s_tlast;
    logic         m_tvalid;
    logic         m_tready;
    logic [151:0] m_tdata;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [7:0]   cfg_index;
    logic [31:0]  cfg_data;

    verdict_tracker sb = new();

    logic [7:0] rec_bytes[$];
    bit         steady_in;
    int         records_sent;
    int         bytes_sent;
    int         phases;

    crc32_record_validator_top dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // mostly short gaps, the odd long one
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic fault_e pick_fault();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return F_NONE;
        if (r < 95)
            return fault_e'($urandom_range(F_SHORT_HDR, F_LAYOUT_MINOR));
        return F_NOISE;
    endfunction

    task automatic send_byte(input logic [7:0] d, input logic fin);
        int gap;
        gap = steady_in ? 0 : idle_len();
        if (gap > 0)
        begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = d;
        s_tlast  = fin;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_byte(d, fin);
        @(negedge clk);
    endtask

    task automatic send_record();
        steady_in = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < rec_bytes.size(); i++)
            send_byte(rec_bytes[i], i == rec_bytes.size() - 1);
        records_sent++;
        bytes_sent += rec_bytes.size();
    endtask

    task automatic raw_record(input int n, input logic [7:0] v);
        rec_bytes.delete();
        repeat (n) rec_bytes.push_back(v);
        send_record();
    endtask

    // well-formed record for the current settings, then the chosen fault, if any, applied
    task automatic build_record(input fault_e f);
        logic [7:0]  h [crv_pkg::HEADER_BYTES];
        logic [7:0]  pay[$];
        logic [31:0] mg;
        logic [7:0]  fmaj;
        logic [7:0]  fmin;
        logic [15:0] hsize;
        logic [15:0] rtype;
        logic [15:0] smaj;
        logic [15:0] smin;
        logic [15:0] resv;
        logic [31:0] plen;
        logic [31:0] nsend;
        logic [63:0] gen;
        logic [31:0] pcrc;
        logic [31:0] hcrc;
        int          cut;
        mg    = sb.magic;
        fmaj  = sb.fmt_major;
        fmin  = 8'($urandom_range(0, sb.fmt_minor_max));
        hsize = 16'(crv_pkg::HEADER_BYTES);
        resv  = 16'd0;
        gen   = {$urandom, $urandom};
        if (sb.exp_type != sb.any_type)
            rtype = sb.exp_type;
        else
            do rtype = 16'($urandom); while (rtype == sb.any_type);
        if (sb.layout_major != 16'd0)
        begin
            smaj = sb.layout_major;
            smin = 16'($urandom_range(0, sb.layout_minor_max));
        end
        else
        begin
            do smaj = 16'($urandom); while (smaj == 16'd0);
            smin = 16'($urandom);
        end
        plen  = (sb.max_len < 24) ? $urandom_range(0, sb.max_len) : $urandom_range(0, 24);
        nsend = plen;
        case (f)
            F_MAGIC:     mg = mg ^ (32'd1 << $urandom_range(0, 31));
            F_FMT_MAJOR: fmaj = fmaj ^ 8'($urandom_range(1, 255));
            F_FMT_MINOR:
                if (sb.fmt_minor_max != 8'hff)
                    fmin = 8'($urandom_range(sb.fmt_minor_max + 1, 255));
            F_HDR_SIZE:  hsize = hsize ^ 16'($urandom_range(1, 65535));
            F_RESERVED:  resv = 16'($urandom_range(1, 65535));
            F_ANY_TYPE:  rtype = sb.any_type;
            F_SMAJ_ZERO: smaj = 16'd0;
            F_BOUNDS:
            begin
                plen  = sb.max_len + 32'd1;
                nsend = $urandom_range(0, 8);
            end
            F_SHORT_PAY:
            begin
                if (plen == 0)
                    plen = 32'd1;
                nsend = $urandom_range(0, plen - 1);
            end
            F_TRAILING:  nsend = plen + $urandom_range(1, 4);
            F_EXP_TYPE:
                if (sb.exp_type != sb.any_type)
                    do rtype = 16'($urandom);
                    while (rtype == sb.exp_type || rtype == sb.any_type);
            F_LAYOUT_MAJOR:
                if (sb.layout_major != 16'd0)
                    do smaj = 16'($urandom);
                    while (smaj == 16'd0 || smaj == sb.layout_major);
            F_LAYOUT_MINOR:
                if (sb.layout_major != 16'd0 && sb.layout_minor_max != 16'hffff)
                    smin = 16'($urandom_range(sb.layout_minor_max + 1, 65535));
            default: ;
        endcase
        pcrc = 32'hffff_ffff;
        repeat (nsend)
        begin
            pay.push_back(8'($urandom));
            pcrc = sb.crc_step(pcrc, pay[$]);
        end
        pcrc = ~pcrc;
        if (f == F_PAY_CRC)
            pcrc = pcrc ^ (32'd1 << $urandom_range(0, 31));
        {h[3], h[2], h[1], h[0]}     = mg;
        h[4]                         = fmaj;
        h[5]                         = fmin;
        {h[7], h[6]}                 = hsize;
        {h[9], h[8]}                 = rtype;
        {h[11], h[10]}               = smaj;
        {h[13], h[12]}               = smin;
        {h[15], h[14]}               = resv;
        {h[19], h[18], h[17], h[16]} = plen;
        {h[27], h[26], h[25], h[24], h[23], h[22], h[21], h[20]} = gen;
        {h[31], h[30], h[29], h[28]} = pcrc;
        hcrc = 32'hffff_ffff;
        for (int i = 0; i < crv_pkg::HDR_CRC_SPAN; i++)
            hcrc = sb.crc_step(hcrc, h[i]);
        hcrc = ~hcrc;
        if (f == F_HDR_CRC)
            hcrc = hcrc ^ (32'd1 << $urandom_range(0, 31));
        {h[35], h[34], h[33], h[32]} = hcrc;
        rec_bytes.delete();
        foreach (h[i])
            rec_bytes.push_back(h[i]);
        foreach (pay[i])
            rec_bytes.push_back(pay[i]);
        if (f == F_SHORT_HDR)
        begin
            cut = $urandom_range(1, crv_pkg::HEADER_BYTES - 1);
            while (rec_bytes.size() > cut)
                void'(rec_bytes.pop_back());
        end
        else if (f == F_NOISE)
        begin
            rec_bytes.delete();
            repeat ($urandom_range(1, 80)) rec_bytes.push_back(8'($urandom));
        end
    endtask

    task automatic run_records(input int n);
        repeat (n)
        begin
            build_record(pick_fault());
            send_record();
        end
    endtask

    // block idle: input dropped, nothing outstanding, then the pipeline left to drain
    task automatic settle();
        s_tvalid = 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [7:0] idx, input logic [31:0] d);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = d;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.write_reg(idx, d);
        @(negedge clk);
    endtask

    // junk in the unused upper bits of the narrow registers
    task automatic apply_config(input logic [31:0] mg, input logic [7:0] fmaj,
                                input logic [7:0] fmin, input logic [31:0] mlen,
                                input logic [15:0] any, input logic [15:0] exp_t,
                                input logic [15:0] smaj, input logic [15:0] smin_max);
        write_reg(crv_pkg::REG_MAGIC, mg);
        write_reg(crv_pkg::REG_FMT_MAJOR, {24'($urandom), fmaj});
        write_reg(crv_pkg::REG_FMT_MINOR_MAX, {24'($urandom), fmin});
        write_reg(crv_pkg::REG_MAX_LEN, mlen);
        write_reg(crv_pkg::REG_ANY_TYPE, {16'($urandom), any});
        write_reg(crv_pkg::REG_EXP_TYPE, {16'($urandom), exp_t});
        write_reg(crv_pkg::REG_LAYOUT_MAJOR, {16'($urandom), smaj});
        write_reg(crv_pkg::REG_LAYOUT_MIN_MAX, {16'($urandom), smin_max});
        write_reg(8'($urandom_range(crv_pkg::REG_LAYOUT_MIN_MAX + 1, 255)), $urandom);
        cfg_valid = 1'b0;
        phases++;
    endtask

    initial
    begin
        bit steady_out;
        int n;
        m_tready   = 1'b0;
        steady_out = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if ($urandom_range(0, 19) == 0)
                steady_out = !steady_out;
            n = steady_out ? 0 : idle_len();
            if (n > 0)
            begin
                m_tready = 1'b0;
                repeat (n) @(negedge clk);
            end
            m_tready = 1'b1;
            repeat ($urandom_range(0, 11)) @(negedge clk);
        end
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
                sb.check_verdict(m_tdata);
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        @(posedge rst_n);
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("no handshake for %0d cycles, %0d results outstanding",
                 QUIET_LIMIT, sb.pending());
        $display("crc32_record_validator_top test failed");
        $finish;
    end

    initial
    begin
        string            codes;
        crv_pkg::status_t st_name;
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = 8'd0;
        s_tlast      = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = 8'd0;
        cfg_data     = 32'd0;
        steady_in    = 1'b0;
        records_sent = 0;
        bytes_sent   = 0;
        phases       = 0;
        codes        = "";
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset settings: short records, byte extremes, then each fault once
        raw_record(1, 8'h00);
        raw_record(1, 8'hff);
        raw_record(crv_pkg::HEADER_BYTES - 1, 8'hff);
        raw_record(crv_pkg::HEADER_BYTES, 8'h00);
        for (int f = F_NONE; f <= F_NOISE; f++)
        begin
            build_record(fault_e'(f));
            send_record();
        end
        settle();

        apply_config(32'hffff_ffff, 8'hff, 8'hff, 32'hffff_ffff,
                     16'hffff, 16'hffff, 16'hffff, 16'hffff);
        run_records(2);
        settle();

        apply_config(32'd0, 8'd0, 8'd0, 32'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        run_records(2);
        settle();

        apply_config($urandom, 8'($urandom), 8'($urandom), $urandom_range(0, 30),
                     16'hffff, 16'd0, 16'd1, 16'd0);
        run_records(2);
        settle();

        while (bytes_sent < 1200 || phases < 5)
        begin
            logic [15:0] any;
            any = 16'($urandom);
            apply_config($urandom, 8'($urandom), 8'($urandom),
                         $urandom_range(0, 1) ? 32'($urandom_range(0, 30)) : 32'($urandom),
                         any,
                         $urandom_range(0, 1) ? any : 16'($urandom),
                         $urandom_range(0, 1) ? 16'd0 : 16'($urandom),
                         16'($urandom));
            run_records(2);
            settle();
        end

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        for (int i = 0; i < 11; i++)
            if (sb.seen[i] > 0)
            begin
                st_name = crv_pkg::status_t'(i);
                codes = {codes, $sformatf(" %s=%0d", st_name.name(), sb.seen[i])};
            end
        $display("%0d records (%0d bytes) under %0d register settings",
                 records_sent, bytes_sent, phases);
        $display("%0d results, %0d clean; status mix:%s", sb.checked, sb.clean, codes);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("crc32_record_validator_top test passed");
        else
            $display("crc32_record_validator_top test failed");
        $finish;
    end

endmodule
